// File: hw/rtl/mfd_pkg.sv
// Shared constants, types and control struct for the marked frame deframer.
// Depends on nothing; used by mfd_cell and marked_frame_deframer.
`default_nettype none

package mfd_pkg;

	// Payload store depth and derived widths
	localparam int MAX_PAYLOAD = 32;
	localparam int IDX_W       = $clog2(MAX_PAYLOAD);
	localparam int FILL_W      = $clog2(MAX_PAYLOAD + 1);
	localparam int LEN_W       = 6;

	// Framing and command characters
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_X = 8'h58;
	localparam logic [7:0] CH_M = 8'h4D;
	localparam logic [7:0] CH_Q = 8'h51;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_U = 8'h55;
	localparam logic [7:0] CH_B = 8'h42;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_SET  = 2'd1,
		CMD_ADD  = 2'd2,
		CMD_SUB  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_HUNT_S,
		ST_HUNT_X,
		ST_HUNT_M,
		ST_PAYLOAD,
		ST_PLAY
	} state_t;

	// Control broadcast to every cell of the chain
	typedef struct packed {
		logic       load;
		logic       shift;
		logic [7:0] data;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/mfd_cell.sv
// One byte cell of the payload chain: loads a received byte when selected,
// or takes its neighbor's byte during playback. Depends on mfd_pkg.
`default_nettype none

module mfd_cell (
	input  wire logic                clk,
	input  wire mfd_pkg::cell_ctrl_t ctrl,
	input  wire logic                sel,
	input  wire logic [7:0]          next_byte,
	output logic [7:0]               cell_byte
);

	logic [7:0] byte_q;

	// Shift toward the head during playback, else capture when addressed
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			byte_q <= next_byte;
		end else if (ctrl.load && sel) begin
			byte_q <= ctrl.data;
		end
	end

	assign cell_byte = byte_q;

endmodule

`default_nettype wire

// File: hw/rtl/marked_frame_deframer.sv
// Marked frame deframer top level: header hunt, payload cell chain, playback.
// Depends on mfd_pkg and mfd_cell.
`default_nettype none

// Accepts one received byte per cycle while hunting for the S X M header and
// while collecting payload into a chain of MAX_PAYLOAD byte cells. On Q the
// input stalls and the frame plays out through a single output register,
// one result per cycle while the output side does not stall: one result per
// payload byte, or a single result for an empty frame. Playback drains the chain by
// shifting every cell one place toward the head for each byte played. All results of a
// frame carry the same command, set_flag and payload_length; last marks the
// final one. A payload byte arriving with the chain full drops the frame.
module marked_frame_deframer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [7:0]                  rx_byte,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [7:0]                       payload_byte,
	output logic                             byte_valid,
	output logic                             last,
	output logic [1:0]                       command,
	output logic                             set_flag,
	output logic [mfd_pkg::LEN_W-1:0]        payload_length
);

	mfd_pkg::state_t               state_q, state_d;
	logic [mfd_pkg::FILL_W-1:0]    fill_q, fill_d;
	logic [mfd_pkg::FILL_W-1:0]    remain_q, remain_d;
	logic [mfd_pkg::FILL_W-1:0]    len_q, len_d;
	mfd_pkg::cmd_t                 cmd_q, cmd_d;
	logic                          toggle_q, toggle_d;
	mfd_pkg::cell_ctrl_t           ctrl;
	logic                          in_fire;
	logic                          slot_free;
	logic                          out_load;
	logic                          last_now;
	mfd_pkg::cmd_t                 classify;
	logic [7:0]                    cells [mfd_pkg::MAX_PAYLOAD];

	logic                          out_valid_q;
	logic [7:0]                    payload_byte_q;
	logic                          byte_valid_q;
	logic                          last_q;
	mfd_pkg::cmd_t                 command_q;
	logic                          set_flag_q;
	logic [mfd_pkg::LEN_W-1:0]     payload_length_q;

	// Cell chain: each cell hands its byte to the one below during playback
	for (genvar i = 0; i < mfd_pkg::MAX_PAYLOAD; i++) begin : g_cell
		logic [7:0] next_byte;
		logic       sel;
		if (i == mfd_pkg::MAX_PAYLOAD - 1) begin : g_tail
			assign next_byte = 8'h00;
		end else begin : g_mid
			assign next_byte = cells[i+1];
		end
		assign sel = (fill_q[mfd_pkg::IDX_W-1:0] == mfd_pkg::IDX_W'(i));
		mfd_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.sel       (sel),
			.next_byte (next_byte),
			.cell_byte (cells[i])
		);
	end

	assign in_stall  = (state_q == mfd_pkg::ST_PLAY);
	assign in_fire   = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign last_now  = (remain_q <= mfd_pkg::FILL_W'(1));

	// Match the whole payload against the three command words
	always_comb begin
		classify = mfd_pkg::CMD_NONE;
		if (fill_q == mfd_pkg::FILL_W'(3)) begin
			if (cells[0] == mfd_pkg::CH_S && cells[1] == mfd_pkg::CH_E &&
			    cells[2] == mfd_pkg::CH_T) begin
				classify = mfd_pkg::CMD_SET;
			end else if (cells[0] == mfd_pkg::CH_A && cells[1] == mfd_pkg::CH_D &&
			             cells[2] == mfd_pkg::CH_D) begin
				classify = mfd_pkg::CMD_ADD;
			end else if (cells[0] == mfd_pkg::CH_S && cells[1] == mfd_pkg::CH_U &&
			             cells[2] == mfd_pkg::CH_B) begin
				classify = mfd_pkg::CMD_SUB;
			end
		end
	end

	// Next state, cell control and playback sequencing
	always_comb begin
		state_d    = state_q;
		fill_d     = fill_q;
		remain_d   = remain_q;
		len_d      = len_q;
		cmd_d      = cmd_q;
		toggle_d   = toggle_q;
		ctrl.load  = 1'b0;
		ctrl.shift = 1'b0;
		ctrl.data  = rx_byte;
		out_load   = 1'b0;
		case (state_q)
			mfd_pkg::ST_HUNT_S: begin
				if (in_fire) begin
					state_d = (rx_byte == mfd_pkg::CH_S) ? mfd_pkg::ST_HUNT_X
					                                     : mfd_pkg::ST_HUNT_S;
				end
			end
			mfd_pkg::ST_HUNT_X: begin
				if (in_fire) begin
					state_d = (rx_byte == mfd_pkg::CH_X) ? mfd_pkg::ST_HUNT_M
					                                     : mfd_pkg::ST_HUNT_S;
				end
			end
			mfd_pkg::ST_HUNT_M: begin
				if (in_fire) begin
					if (rx_byte == mfd_pkg::CH_M) begin
						state_d = mfd_pkg::ST_PAYLOAD;
						fill_d  = '0;
					end else begin
						state_d = mfd_pkg::ST_HUNT_S;
					end
				end
			end
			mfd_pkg::ST_PAYLOAD: begin
				if (in_fire) begin
					if (rx_byte == mfd_pkg::CH_Q) begin
						cmd_d    = classify;
						toggle_d = toggle_q ^ (classify == mfd_pkg::CMD_SET);
						len_d    = fill_q;
						remain_d = fill_q;
						fill_d   = '0;
						state_d  = mfd_pkg::ST_PLAY;
					end else if (fill_q < mfd_pkg::FILL_W'(mfd_pkg::MAX_PAYLOAD)) begin
						ctrl.load = 1'b1;
						fill_d    = fill_q + mfd_pkg::FILL_W'(1);
					end else begin
						fill_d  = '0;
						state_d = mfd_pkg::ST_HUNT_S;
					end
				end
			end
			mfd_pkg::ST_PLAY: begin
				if (slot_free) begin
					out_load   = 1'b1;
					ctrl.shift = (len_q != '0);
					if (remain_q != '0) begin
						remain_d = remain_q - mfd_pkg::FILL_W'(1);
					end
					if (last_now) begin
						state_d = mfd_pkg::ST_HUNT_S;
					end
				end
			end
			default: begin
				state_d = mfd_pkg::ST_HUNT_S;
			end
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mfd_pkg::ST_HUNT_S;
			fill_q   <= '0;
			remain_q <= '0;
			len_q    <= '0;
			cmd_q    <= mfd_pkg::CMD_NONE;
			toggle_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			remain_q <= remain_d;
			len_q    <= len_d;
			cmd_q    <= cmd_d;
			toggle_q <= toggle_d;
		end
	end

	// Output valid: set on load, drop once the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload: head cell or the empty frame marker
	always_ff @(posedge clk) begin
		if (out_load) begin
			payload_byte_q   <= (len_q != '0) ? cells[0] : 8'h00;
			byte_valid_q     <= (len_q != '0);
			last_q           <= last_now;
			command_q        <= cmd_q;
			set_flag_q       <= toggle_q;
			payload_length_q <= mfd_pkg::LEN_W'(len_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign payload_byte   = payload_byte_q;
	assign byte_valid     = byte_valid_q;
	assign last           = last_q;
	assign command        = command_q;
	assign set_flag       = set_flag_q;
	assign payload_length = payload_length_q;

	// Fill never passes the chain depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= mfd_pkg::FILL_W'(mfd_pkg::MAX_PAYLOAD))
		else $error("fill count beyond chain depth");

	// An empty marker is always the last and only result of its frame
	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !byte_valid_q) |-> (last_q && payload_length_q == '0))
		else $error("empty marker malformed");

	// Playback never runs out of bytes before finishing
	a_play_remain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mfd_pkg::ST_PLAY) |-> (remain_q != '0 || len_q == '0))
		else $error("playback overran payload");

	// The kept flag changes only on a SET frame
	a_toggle_set: assert property (@(posedge clk) disable iff (!arst_n)
		(toggle_q != $past(toggle_q)) |-> (cmd_q == mfd_pkg::CMD_SET))
		else $error("flag toggled without SET");

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for marked_frame_deframer: header hunt, payload capture, playback.
// Depends on mfd_pkg and the marked_frame_deframer RTL; a scoreboard class predicts each frame.
`timescale 1ns / 1ps

module tb;
	import mfd_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_BYTES = 385;

	// One playback result as seen on the output ports
	typedef struct {
		logic [7:0]       payload_byte;
		logic             byte_valid;
		logic             last;
		cmd_t             command;
		logic             set_flag;
		logic [LEN_W-1:0] payload_length;
	} frame_result_t;

	typedef enum int {WAIT_S, WAIT_X, WAIT_M, IN_PAYLOAD} hunt_t;

	// Predict playback of each frame and compare against what the block emits
	class frame_scoreboard;
		hunt_t         stage;
		int            fill;
		logic [7:0]    store [MAX_PAYLOAD];
		logic          flag;
		frame_result_t expected_results [$];
		int            failures;

		function new();
			stage = WAIT_S;
			fill = 0;
			flag = 1'b0;
			failures = 0;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function bit word_is(logic [7:0] a, logic [7:0] b, logic [7:0] c);
			return fill == 3 && store[0] == a && store[1] == b && store[2] == c;
		endfunction

		// Play the stored payload out as expected results
		function void close_frame();
			cmd_t          cmd;
			frame_result_t r;
			int            k;
			cmd = CMD_NONE;
			if (word_is(CH_S, CH_E, CH_T)) begin
				cmd = CMD_SET;
				flag = ~flag;
			end else if (word_is(CH_A, CH_D, CH_D)) begin
				cmd = CMD_ADD;
			end else if (word_is(CH_S, CH_U, CH_B)) begin
				cmd = CMD_SUB;
			end
			r.command = cmd;
			r.set_flag = flag;
			r.payload_length = fill[LEN_W-1:0];
			if (fill == 0) begin
				r.payload_byte = 8'h00;
				r.byte_valid = 1'b0;
				r.last = 1'b1;
				expected_results.push_back(r);
			end else begin
				for (k = 0; k < fill; k++) begin
					r.payload_byte = store[k];
					r.byte_valid = 1'b1;
					r.last = (k == fill - 1);
					expected_results.push_back(r);
				end
			end
			stage = WAIT_S;
			fill = 0;
		endfunction

		// Advance the predicted state by one accepted byte
		function void note_byte(logic [7:0] b);
			if (stage == IN_PAYLOAD) begin
				if (b == CH_Q) begin
					close_frame();
				end else if (fill < MAX_PAYLOAD) begin
					store[fill] = b;
					fill++;
				end else begin
					// overflow: drop the frame
					fill = 0;
					stage = WAIT_S;
				end
			end else if (stage == WAIT_S && b == CH_S) begin
				stage = WAIT_X;
			end else if (stage == WAIT_X && b == CH_X) begin
				stage = WAIT_M;
			end else if (stage == WAIT_M && b == CH_M) begin
				stage = IN_PAYLOAD;
				fill = 0;
			end else begin
				stage = WAIT_S;
			end
		endfunction

		function string show(frame_result_t r);
			return $sformatf("byte %02h valid %0d last %0d cmd %0d flag %0d len %0d",
				r.payload_byte, r.byte_valid, r.last, r.command, r.set_flag,
				r.payload_length);
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t want;
			if (expected_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: %s", show(got));
				return;
			end
			want = expected_results.pop_front();
			if (got.payload_byte !== want.payload_byte || got.byte_valid !== want.byte_valid ||
			    got.last !== want.last || got.command !== want.command ||
			    got.set_flag !== want.set_flag ||
			    got.payload_length !== want.payload_length) begin
				failures++;
				if (failures <= 10)
					$display("result mismatch at %0t: expected %s, got %s", $realtime,
						show(want), show(got));
			end
		endfunction

		// Count every expectation still waiting as a failure
		function void close_out();
			if (expected_results.size() != 0) begin
				failures += expected_results.size();
				$display("%0d expected results never arrived", expected_results.size());
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [7:0]           rx_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [7:0]           payload_byte;
	logic                 byte_valid;
	logic                 last;
	logic [1:0]           command;
	logic                 set_flag;
	logic [LEN_W-1:0]     payload_length;

	frame_scoreboard sb = new();
	bit              quiet;
	int              idle_cycles;

	marked_frame_deframer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.payload_byte   (payload_byte),
		.byte_valid     (byte_valid),
		.last           (last),
		.command        (command),
		.set_flag       (set_flag),
		.payload_length (payload_length)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Record every transaction on both channels
	always @(posedge clk) begin
		frame_result_t got;
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_byte(rx_byte);
			if (out_valid && !out_stall) begin
				got.payload_byte = payload_byte;
				got.byte_valid = byte_valid;
				got.last = last;
				got.command = cmd_t'(command);
				got.set_flag = set_flag;
				got.payload_length = payload_length;
				sb.check_result(got);
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// Output side: random stall before each result
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 5);
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			@(negedge clk);
		end
	end

	// Present one byte after a random gap and hold it until taken
	task send_byte(input logic [7:0] b);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!(in_valid && !in_stall));
		@(negedge clk);
	endtask

	task send_text(input string s);
		int k;
		for (k = 0; k < s.len(); k++)
			send_byte(s[k]);
	endtask

	function logic [7:0] any_but_q();
		logic [7:0] b;
		do b = 8'($urandom); while (b == CH_Q);
		return b;
	endfunction

	// Header, len random payload bytes, then Q
	task send_random_frame(input int len);
		int k;
		send_text("SXM");
		for (k = 0; k < len; k++)
			send_byte(any_but_q());
		send_byte(CH_Q);
	endtask

	// Hold the input off until every expected result has come
	task drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	initial begin
		string words [8];
		int    frame_bytes;
		int    kind;
		int    len;
		int    burst;
		words = '{"SET", "ADD", "SUB", "SE", "SETT", "SUX", "ADE", "SEB"};
		frame_bytes = 0;
		quiet = 1'b0;
		idle_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		out_stall = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty frame, each command, SET twice, header faults, byte extremes
		send_text("SXMQ");
		send_text("SXMSETQ");
		send_text("SXMADDQ");
		send_text("SXMSUBQ");
		send_text("SSXMQ");
		send_text("SXASXMSETQ");
		send_text("SXM");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_S);
		send_byte(CH_Q);
		drain();

		// Random: mostly well-formed frames with random content
		while (frame_bytes < RANDOM_BYTES) begin
			quiet = ($urandom_range(0, 5) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				burst = $urandom_range(1, 4);
				repeat (burst) send_byte(8'($urandom));
				frame_bytes += burst;
			end else if (kind < 18) begin
				send_byte(CH_S);
				if ($urandom_range(0, 1) != 0)
					send_byte(CH_X);
				send_byte(8'($urandom));
				frame_bytes += 3;
			end else if (kind < 38) begin
				send_text({"SXM", words[$urandom_range(0, 7)], "Q"});
				frame_bytes += 7;
			end else begin
				// long frames run up to a full store, and one byte past it overflows
				len = (kind < 44) ? $urandom_range(30, 33) : $urandom_range(0, 8);
				send_random_frame(len);
				frame_bytes += len + 4;
			end
			if ($urandom_range(0, 15) == 0)
				drain();
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		sb.close_out();
		if (sb.failures == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
